// File: src/rm3014_pkg.sv
// shared constants, types, parity-check masks and vote functions for the rm(30,14) decoder
package rm3014_pkg;

  localparam int WordWidth     = 30;
  localparam int InfoBits      = 14;
  localparam int ParityBits    = 16;
  localparam int ChecksPerBit  = 4;
  localparam int VotesPerBit   = ChecksPerBit + 1;
  localparam int VoteThreshold = 3;
  localparam int VoteCntWidth  = $clog2(VotesPerBit + 1);
  localparam int VoteVecWidth  = InfoBits * VotesPerBit;

  typedef logic [ParityBits-1:0]  mask_t;
  typedef logic [VotesPerBit-1:0] votes_t;

  // leftmost bit is parity bit p1, rightmost is p16
  localparam mask_t CheckMasks [InfoBits][ChecksPerBit] = '{
    '{16'b0010_1110_0010_0000, 16'b1100_1101_1000_0000,
      16'b0111_1000_1100_0000, 16'b1001_1011_0110_0000},
    '{16'b1001_1000_1010_0000, 16'b1100_1110_0100_0000,
      16'b0111_1011_0000_0000, 16'b0010_1101_1110_0000},
    '{16'b0100_1001_0110_0000, 16'b1010_1010_1100_0000,
      16'b0001_1111_1000_0000, 16'b1111_1100_0010_0000},
    '{16'b0000_0011_1001_1100, 16'b1110_0000_0011_1100,
      16'b0101_0101_0111_1100, 16'b1011_0110_1101_1100},
    '{16'b1001_1000_0011_1010, 16'b0010_1101_0111_1010,
      16'b1100_1110_1101_1010, 16'b0111_1011_1001_1010},
    '{16'b0000_0010_1101_0110, 16'b0101_0100_0011_0110,
      16'b1110_0001_0111_0110, 16'b1011_0111_1001_0110},
    '{16'b0010_1100_0010_1110, 16'b1001_1001_0110_1110,
      16'b1100_1111_1000_1110, 16'b0111_1010_1100_1110},
    '{16'b0100_1010_1001_1111, 16'b1010_1001_0011_1111,
      16'b0001_1100_0111_1111, 16'b1111_1111_1101_1111},
    '{16'b0110_0000_1001_1001, 16'b1000_0011_0011_1001,
      16'b0011_0110_0111_1001, 16'b1101_0101_1101_1001},
    '{16'b1010_0001_0001_0101, 16'b0001_0100_0101_0101,
      16'b0100_0010_1011_0101, 16'b1111_0111_1111_0101},
    '{16'b1100_0010_0000_1101, 16'b0010_0001_1010_1101,
      16'b1001_0100_1110_1101, 16'b0111_0111_0100_1101},
    '{16'b0100_0100_1001_0011, 16'b0001_0010_0111_0011,
      16'b1010_0111_0011_0011, 16'b1111_0001_1101_0011},
    '{16'b0000_1001_0110_1011, 16'b1011_1100_0010_1011,
      16'b1110_1010_1100_1011, 16'b0101_1111_1000_1011},
    '{16'b0101_0010_0000_0111, 16'b0000_0100_1110_0111,
      16'b1011_0001_1010_0111, 16'b1110_0111_0100_0111}
  };

  // majority over the votes of one info bit
  function automatic logic majority(input votes_t v);
    logic [VoteCntWidth-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < VotesPerBit; k++) begin
      cnt = cnt + VoteCntWidth'(v[k]);
    end
    return (cnt >= VoteCntWidth'(VoteThreshold));
  endfunction

  // all info bits from a flat vote vector, element 0 lands on the top bit
  function automatic logic [InfoBits-1:0] decode_votes(input logic [VoteVecWidth-1:0] vv);
    logic [InfoBits-1:0] res;
    for (int i = 0; i < InfoBits; i++) begin
      res[InfoBits-1-i] = majority(vv[i*VotesPerBit +: VotesPerBit]);
    end
    return res;
  endfunction

endpackage

// File: src/rm_30_14_majority_decoder_core.sv
// rm(30,14) majority-logic decoder, three-stage valid/ready pipeline
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   received_word_i [29:0]
//  out      source     out_valid_o / out_ready_i decoded_bits_o  [13:0]
//
// one transaction per cycle sustained while out_ready_i does not stall
// stages: input register, vote register (parity xor trees), output register (majority)
// reset clears the stage valid bits only, nothing else is held between transactions
// a stall on out_ready_i fills the stages back to front before in_ready_o drops
module rm_30_14_majority_decoder_core
  import rm3014_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WordWidth-1:0] received_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [InfoBits-1:0]  decoded_bits_o
);

  logic                    s1_valid;
  logic                    s1_ready;
  logic [WordWidth-1:0]    s1_word;
  logic [VoteVecWidth-1:0] s1_votes;
  logic                    s2_valid;
  logic                    s2_ready;
  logic [VoteVecWidth-1:0] s2_votes;
  logic [InfoBits-1:0]     s2_bits;

  rm3014_stage #(
    .Width(WordWidth)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (received_word_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_word)
  );

  rm3014_check u_check (
    .word_i  (s1_word),
    .votes_o (s1_votes)
  );

  rm3014_stage #(
    .Width(VoteVecWidth)
  ) u_vote_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_votes),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_votes)
  );

  rm3014_vote u_vote (
    .votes_i (s2_votes),
    .bits_o  (s2_bits)
  );

  rm3014_stage #(
    .Width(InfoBits)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_bits),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (decoded_bits_o)
  );

`ifndef NO_ASSERTIONS
  // input backpressure only when the whole pipe is full and stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && s2_valid && out_valid_o && !out_ready_i))
    else $error("in_ready_o low with a free pipeline slot");

  // an accepted transaction occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid)
    else $error("accepted transaction lost at the input stage");

  // a transaction moving into the output register carries its majority result
  a_out_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && s2_ready) |=>
      (out_valid_o && decoded_bits_o == decode_votes($past(s2_votes))))
    else $error("output register does not match majority of votes");
`endif

endmodule

// File: src/rm3014_stage.sv
// one valid/ready pipeline register stage
module rm3014_stage
  import rm3014_pkg::*;
#(
  parameter int Width = WordWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic             valid_d;
  logic [Width-1:0] data_q;
  logic [Width-1:0] data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d = valid_i;
      data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/rm3014_check.sv
// parity-check estimates and received info bits, five votes per info bit
module rm3014_check
  import rm3014_pkg::*;
(
  input  logic [WordWidth-1:0]    word_i,
  output logic [VoteVecWidth-1:0] votes_o
);

  logic [ParityBits-1:0] parity;

  assign parity = word_i[ParityBits-1:0];

  always_comb begin
    for (int i = 0; i < InfoBits; i++) begin
      votes_o[i*VotesPerBit] = word_i[WordWidth-1-i];
      for (int j = 0; j < ChecksPerBit; j++) begin
        votes_o[i*VotesPerBit + 1 + j] = ^(parity & CheckMasks[i][j]);
      end
    end
  end

endmodule

// File: src/rm3014_vote.sv
// majority vote per info bit
module rm3014_vote
  import rm3014_pkg::*;
(
  input  logic [VoteVecWidth-1:0] votes_i,
  output logic [InfoBits-1:0]     bits_o
);

  assign bits_o = decode_votes(votes_i);

endmodule

// File: verif/testbench.sv
// testbench for the rm(30,14) majority-logic decoder core: directed, back-to-back, output stall and random tests
`timescale 1ns / 100ps

module testbench;
  import rm3014_pkg::WordWidth;
  import rm3014_pkg::InfoBits;

  localparam logic [15:0] ParityChecks [14][4] = '{
    '{16'h2E20, 16'hCD80, 16'h78C0, 16'h9B60},
    '{16'h98A0, 16'hCE40, 16'h7B00, 16'h2DE0},
    '{16'h4960, 16'hAAC0, 16'h1F80, 16'hFC20},
    '{16'h039C, 16'hE03C, 16'h557C, 16'hB6DC},
    '{16'h983A, 16'h2D7A, 16'hCEDA, 16'h7B9A},
    '{16'h02D6, 16'h5436, 16'hE176, 16'hB796},
    '{16'h2C2E, 16'h996E, 16'hCF8E, 16'h7ACE},
    '{16'h4A9F, 16'hA93F, 16'h1C7F, 16'hFFDF},
    '{16'h6099, 16'h8339, 16'h3679, 16'hD5D9},
    '{16'hA115, 16'h1455, 16'h42B5, 16'hF7F5},
    '{16'hC20D, 16'h21AD, 16'h94ED, 16'h774D},
    '{16'h4493, 16'h1273, 16'hA733, 16'hF1D3},
    '{16'h096B, 16'hBC2B, 16'hEACB, 16'h5F8B},
    '{16'h5207, 16'h04E7, 16'hB1A7, 16'hE747}
  };
  localparam int MajorityLevel = 3;
  localparam int DrainCycles   = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [WordWidth-1:0] received_word;
  logic                 out_valid;
  logic                 out_ready;
  logic [InfoBits-1:0]  decoded_bits;

  logic [InfoBits-1:0] pending_bits [$];
  int src_idle_max;
  int snk_idle_max;
  int hold_off_cycles;
  int words_sent;
  int words_checked;
  int mismatches;

  rm_30_14_majority_decoder_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .received_word_i (received_word),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .decoded_bits_o  (decoded_bits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [InfoBits-1:0] majority_decode(input logic [WordWidth-1:0] word);
    logic [InfoBits-1:0] bits;
    int votes;
    bits = '0;
    for (int i = 0; i < InfoBits; i++) begin
      votes = int'(word[WordWidth-1-i]);
      for (int j = 0; j < 4; j++) begin
        votes += int'(^(word[15:0] & ParityChecks[i][j]));
      end
      bits[InfoBits-1-i] = (votes >= MajorityLevel);
    end
    return bits;
  endfunction

  function automatic logic [WordWidth-1:0] draw_word();
    logic [WordWidth-1:0] w;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      w = WordWidth'($urandom);
    end else begin
      w = '0;
      repeat ($urandom_range(1, 3)) w[$urandom_range(0, WordWidth-1)] ^= 1'b1;
      if (kind > 7) begin
        w = ~w;
      end
    end
    return w;
  endfunction

  // called at a rising edge; leaves valid high when the next transaction follows at once
  task automatic send_word(input logic [WordWidth-1:0] w);
    int gap;
    in_valid      <= 1'b1;
    received_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_bits.insert(pending_bits.size(), majority_decode(w));
    words_sent++;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    logic [WordWidth-1:0] words [$] = '{
      30'h00000000, 30'h3FFFFFFF, 30'h3FFF0000, 30'h0000FFFF, 30'h2AAAAAAA,
      30'h15555555, 30'h20000000, 30'h00010000, 30'h00008000, 30'h00000001,
      30'h1FFFFFFF, 30'h3FFEFFFF, 30'h3FFF7FFF, 30'h3FFFFFFE, 30'h0000C000,
      30'h20000001, 30'h30000000, 30'h3FFFC000
    };
    src_idle_max = 8;
    snk_idle_max = 8;
    foreach (words[k]) send_word(words[k]);
  endtask

  task automatic test_back_to_back();
    src_idle_max = 0;
    snk_idle_max = 0;
    repeat (200) send_word(draw_word());
  endtask

  task automatic test_output_stall();
    src_idle_max    = 0;
    snk_idle_max    = 0;
    hold_off_cycles = 60;
    repeat (30) send_word(draw_word());
  endtask

  task automatic test_random();
    src_idle_max = 8;
    snk_idle_max = 8;
    repeat (1700) send_word(draw_word());
  endtask

  // receiver: random stall before each transaction, one long hold-off on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, snk_idle_max);
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    logic [InfoBits-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bits.size() == 0) begin
        $error("decoded_bits unexpected: expected none, actual %h", decoded_bits);
        mismatches++;
      end else begin
        want = pending_bits.pop_front();
        words_checked++;
        if (decoded_bits !== want) begin
          $error("decoded_bits mismatch: expected %h, actual %h", want, decoded_bits);
          mismatches++;
        end
      end
    end
  end

  initial begin
    src_idle_max    = 0;
    snk_idle_max    = 0;
    hold_off_cycles = 0;
    words_sent      = 0;
    words_checked   = 0;
    mismatches      = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    received_word <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_output_stall();
    test_random();
    in_valid <= 1'b0;

    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d codewords (directed, back-to-back, long output stall, random idling)",
             words_sent);
    $display("compared %0d decoded results, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
